/* hdl/lfpd_pkg.sv */
package lfpd_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int SENSOR_COUNT = 5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd6;

    localparam logic [9:0] P_GAIN_RST = 10'd150;
    localparam logic [15:0] I_PERIOD_RST = 16'd1250;
    localparam logic [15:0] D_GAIN_RST = 16'd65535;
    localparam logic [9:0] BASE_DUTY_RST = 10'd700;
    localparam logic [9:0] MAX_DUTY_RST = 10'd800;
    localparam logic [14:0] DRIVE_LIMIT_RST = 15'd1600;
    localparam logic [13:0] INT_LIMIT_RST = 14'd3273;

    localparam logic [SENSOR_COUNT-1:0] PAT_R1 = 5'b00110;
    localparam logic [SENSOR_COUNT-1:0] PAT_R2 = 5'b00010;
    localparam logic [SENSOR_COUNT-1:0] PAT_R3 = 5'b00011;
    localparam logic [SENSOR_COUNT-1:0] PAT_R4 = 5'b00001;
    localparam logic [SENSOR_COUNT-1:0] PAT_L1 = 5'b01100;
    localparam logic [SENSOR_COUNT-1:0] PAT_L2 = 5'b01000;
    localparam logic [SENSOR_COUNT-1:0] PAT_L3 = 5'b11000;
    localparam logic [SENSOR_COUNT-1:0] PAT_L4 = 5'b10000;
    localparam logic [SENSOR_COUNT-1:0] PAT_CW = 5'b00111;
    localparam logic [SENSOR_COUNT-1:0] PAT_CCW = 5'b11100;
    localparam logic [SENSOR_COUNT-1:0] PAT_NONE = 5'b00000;
    localparam logic [SENSOR_COUNT-1:0] PAT_ALL = 5'b11111;

    localparam logic [2:0] REC_NONE = 3'd0;
    localparam logic [2:0] REC_SHARP_CW = 3'd1;
    localparam logic [2:0] REC_SHARP_CCW = 3'd2;
    localparam logic [2:0] REC_SEARCH = 3'd3;
    localparam logic [2:0] REC_STOP = 3'd4;

endpackage

/* hdl/lfpd_if.sv */
interface lfpd_in_if #(
    parameter int TIMER_BITS = lfpd_pkg::TIMER_BITS_DEF
);
    import lfpd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SENSOR_COUNT-1:0] sensor_pattern;
    logic [TIMER_BITS-1:0]   timer_value;
    logic                    timer_overflow;

    modport source (
        output valid,
        output sensor_pattern,
        output timer_value,
        output timer_overflow,
        input  ready
    );

    modport sink (
        input  valid,
        input  sensor_pattern,
        input  timer_value,
        input  timer_overflow,
        output ready
    );
endinterface

interface lfpd_out_if;
    logic              valid;
    logic              ready;
    logic [9:0]        left_duty;
    logic              left_forward;
    logic [9:0]        right_duty;
    logic              right_forward;
    logic signed [15:0] drive_command;
    logic [2:0]        recovery_code;

    modport source (
        output valid,
        output left_duty,
        output left_forward,
        output right_duty,
        output right_forward,
        output drive_command,
        output recovery_code,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_duty,
        input  left_forward,
        input  right_duty,
        input  right_forward,
        input  drive_command,
        input  recovery_code,
        output ready
    );
endinterface

/* hdl/line_follow_pid_drive.sv */
// The block takes a new input transaction only after the previous one has been committed:
// in_ch.ready is high only in the idle state, and commit waits on both dividers and a free output.
// Two bit-serial dividers run side by side: the timer remainder for the integral gate
// and the derivative gain quotient, one bit per cycle each.
// Reset (rst_n low, asynchronous) loads the default gains and limits and clears
// the error history, integral, derivative, last drive, turn flags and output valid.
module line_follow_pid_drive #(
    parameter int TIMER_BITS = lfpd_pkg::TIMER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    lfpd_in_if.sink                        in_ch,
    lfpd_out_if.source                     out_ch
);
    import lfpd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN = 1'b1;

    logic [9:0]  p_gain_reg;
    logic [15:0] i_period_reg;
    logic [15:0] d_gain_reg;
    logic [9:0]  base_duty_reg;
    logic [9:0]  max_duty_reg;
    logic [14:0] drive_limit_reg;
    logic [13:0] int_limit_reg;

    logic              state_reg;
    logic signed [3:0] hist0_reg;
    logic signed [3:0] hist1_reg;
    logic signed [3:0] hist2_reg;
    logic signed [13:0] integ_reg;
    logic signed [20:0] deriv_reg;
    logic signed [15:0] last_drive_reg;
    logic              cw_reg;
    logic              ccw_reg;
    logic              ovf_reg;
    logic [2:0]        code_reg;
    logic              out_valid_reg;

    logic [9:0]         left_duty_reg;
    logic               left_fwd_reg;
    logic [9:0]         right_duty_reg;
    logic               right_fwd_reg;
    logic signed [15:0] drive_reg;
    logic [2:0]         rec_code_reg;

    logic              accept;
    logic              commit;
    logic signed [3:0] hist2_next;
    logic              cw_next;
    logic              ccw_next;
    logic [2:0]        code_next;
    logic              int_clr;

    logic [TIMER_BITS-1:0] tdiv;
    logic [TIMER_BITS-1:0] qden;
    logic [15:0]           per;
    logic                  mod_done;
    logic [TIMER_BITS-1:0] mod_quot;
    logic [15:0]           mod_rem;
    logic                  quot_done;
    logic [15:0]           quot;
    logic [TIMER_BITS-1:0] quot_rem;

    logic signed [3:0]  e;
    logic signed [16:0] dl_s;
    logic signed [16:0] ld_s;
    logic signed [15:0] ilim_s;
    logic signed [15:0] ilo_s;
    logic signed [15:0] integ_s;
    logic signed [14:0] integ_sum;
    logic               sat_hi;
    logic               sat_lo;
    logic               int_hi;
    logic               int_lo;
    logic               e_neg;
    logic               e_pos;
    logic               int_upd;
    logic signed [13:0] integ_next;
    logic               changed;
    logic signed [3:0]  h0a;
    logic signed [3:0]  h1a;
    logic signed [3:0]  hist0_next;
    logic signed [3:0]  hist1_next;
    logic signed [4:0]  diff;
    logic signed [16:0] quot_s;
    logic signed [21:0] prod;
    logic signed [20:0] deriv_next;
    logic signed [14:0] pe;
    logic signed [21:0] sum_s;
    logic signed [15:0] drive_next;
    logic [9:0]         left_duty_next;
    logic               left_fwd_next;
    logic [9:0]         right_duty_next;
    logic               right_fwd_next;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign commit = (state_reg == ST_RUN) && mod_done && quot_done
                    && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        hist2_next = hist2_reg;
        cw_next = cw_reg;
        ccw_next = ccw_reg;
        code_next = REC_NONE;
        int_clr = 1'b0;
        case (in_ch.sensor_pattern)
            PAT_R1: hist2_next = 4'sd1;
            PAT_R2: hist2_next = 4'sd2;
            PAT_R3: hist2_next = 4'sd3;
            PAT_R4: hist2_next = 4'sd4;
            PAT_L1: hist2_next = -4'sd1;
            PAT_L2: hist2_next = -4'sd2;
            PAT_L3: hist2_next = -4'sd3;
            PAT_L4: hist2_next = -4'sd4;
            PAT_CW:
            begin
                cw_next = 1'b1;
                ccw_next = 1'b0;
            end
            PAT_CCW:
            begin
                ccw_next = 1'b1;
                cw_next = 1'b0;
            end
            PAT_NONE:
            begin
                if (hist2_reg > 4'sd1 || hist1_reg > 4'sd1 || cw_reg)
                begin
                    code_next = REC_SHARP_CW;
                    cw_next = 1'b0;
                    int_clr = 1'b1;
                end
                else if (hist2_reg < -4'sd1 || hist1_reg < -4'sd1 || ccw_reg)
                begin
                    code_next = REC_SHARP_CCW;
                    ccw_next = 1'b0;
                    int_clr = 1'b1;
                end
                else
                begin
                    code_next = REC_SEARCH;
                end
            end
            PAT_ALL: code_next = REC_STOP;
            default: hist2_next = 4'sd0;
        endcase
    end

    // A period of zero behaves as one; the overflow case divides by the timer maximum.
    assign per = (i_period_reg == '0) ? 16'd1 : i_period_reg;
    assign tdiv = (in_ch.timer_value == '0) ? TIMER_BITS'(1) : in_ch.timer_value;
    assign qden = in_ch.timer_overflow ? {TIMER_BITS{1'b1}} : tdiv;

    lfpd_divider #(
        .NUM_W (TIMER_BITS),
        .DEN_W (16)
    ) u_mod_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (in_ch.timer_value),
        .den   (per),
        .done  (mod_done),
        .quot  (mod_quot),
        .rem   (mod_rem)
    );

    lfpd_divider #(
        .NUM_W (16),
        .DEN_W (TIMER_BITS)
    ) u_quot_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (d_gain_reg),
        .den   (qden),
        .done  (quot_done),
        .quot  (quot),
        .rem   (quot_rem)
    );

    always_comb
    begin
        e = hist2_reg;
        e_neg = e[3];
        e_pos = !e[3] && (e != 4'sd0);

        dl_s = $signed({2'b00, drive_limit_reg});
        ld_s = 17'(last_drive_reg);
        sat_hi = (ld_s >= dl_s);
        sat_lo = (ld_s <= -dl_s);
        ilim_s = $signed({2'b00, int_limit_reg});
        ilo_s = -ilim_s - 16'sd1;
        integ_s = 16'(integ_reg);
        int_hi = (integ_s >= ilim_s);
        int_lo = (integ_s <= ilo_s);
        int_upd = (mod_rem < 16'd2)
                  && (!(sat_hi || sat_lo) || (sat_hi && e_neg) || (sat_lo && e_pos))
                  && (!(int_hi || int_lo) || (int_hi && e_neg) || (int_lo && e_pos));
        integ_sum = 15'(integ_reg) + 15'(e);
        if (!int_upd)
        begin
            integ_next = integ_reg;
        end
        else if (integ_sum[14] != integ_sum[13])
        begin
            integ_next = integ_sum[14] ? -14'sd8192 : 14'sd8191;
        end
        else
        begin
            integ_next = integ_sum[13:0];
        end

        changed = (hist1_reg != e);
        h0a = changed ? hist1_reg : hist0_reg;
        h1a = changed ? e : hist1_reg;
        hist0_next = ovf_reg ? h1a : h0a;
        hist1_next = ovf_reg ? e : h1a;
        diff = ovf_reg ? (5'(h1a) - 5'(h0a)) : (5'(e) - 5'(hist1_reg));
        quot_s = $signed({1'b0, quot});
        prod = 22'(quot_s) * 22'(diff);
        deriv_next = (ovf_reg || changed) ? prod[20:0] : deriv_reg;

        pe = $signed({1'b0, p_gain_reg}) * 15'(e);
        sum_s = 22'(pe) + 22'(integ_next) + 22'(deriv_next);
        if (sum_s > 22'sd32767)
        begin
            drive_next = 16'sd32767;
        end
        else if (sum_s < -22'sd32768)
        begin
            drive_next = -16'sd32768;
        end
        else
        begin
            drive_next = sum_s[15:0];
        end
    end

    lfpd_motor u_motor (
        .drive         (drive_next),
        .base_duty     (base_duty_reg),
        .max_duty      (max_duty_reg),
        .left_duty     (left_duty_next),
        .left_forward  (left_fwd_next),
        .right_duty    (right_duty_next),
        .right_forward (right_fwd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg <= P_GAIN_RST;
            i_period_reg <= I_PERIOD_RST;
            d_gain_reg <= D_GAIN_RST;
            base_duty_reg <= BASE_DUTY_RST;
            max_duty_reg <= MAX_DUTY_RST;
            drive_limit_reg <= DRIVE_LIMIT_RST;
            int_limit_reg <= INT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P_GAIN: p_gain_reg <= cfg_data[9:0];
                REG_I_PERIOD: i_period_reg <= cfg_data[15:0];
                REG_D_GAIN: d_gain_reg <= cfg_data[15:0];
                REG_BASE_DUTY: base_duty_reg <= cfg_data[9:0];
                REG_MAX_DUTY: max_duty_reg <= cfg_data[9:0];
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_data[14:0];
                REG_INT_LIMIT: int_limit_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            integ_reg <= '0;
            deriv_reg <= '0;
            last_drive_reg <= '0;
            cw_reg <= 1'b0;
            ccw_reg <= 1'b0;
            ovf_reg <= 1'b0;
            code_reg <= REC_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hist2_reg <= hist2_next;
                cw_reg <= cw_next;
                ccw_reg <= ccw_next;
                if (int_clr)
                begin
                    integ_reg <= '0;
                end
                ovf_reg <= in_ch.timer_overflow;
                code_reg <= code_next;
                state_reg <= ST_RUN;
            end
            else if (commit)
            begin
                hist0_reg <= hist0_next;
                hist1_reg <= hist1_next;
                integ_reg <= integ_next;
                deriv_reg <= deriv_next;
                last_drive_reg <= drive_next;
                state_reg <= ST_IDLE;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            left_duty_reg <= left_duty_next;
            left_fwd_reg <= left_fwd_next;
            right_duty_reg <= right_duty_next;
            right_fwd_reg <= right_fwd_next;
            drive_reg <= drive_next;
            rec_code_reg <= code_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.left_duty = left_duty_reg;
    assign out_ch.left_forward = left_fwd_reg;
    assign out_ch.right_duty = right_duty_reg;
    assign out_ch.right_forward = right_fwd_reg;
    assign out_ch.drive_command = drive_reg;
    assign out_ch.recovery_code = rec_code_reg;

`ifndef SYNTHESIS
    // Both dividers must be running in the cycle after a transaction is taken.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!mod_done && !quot_done))
        else $error("divider did not start after input transaction");

    // A new result only appears after the run state finished an item.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("output valid rose without a finished item");

    // The two turn flags are never set together.
    a_turn_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(cw_reg && ccw_reg))
        else $error("both turn flags set");
`endif
endmodule

/* hdl/lfpd_divider.sv */
module lfpd_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   part;
    logic [DEN_W:0]   part_diff;
    logic             ge;

    // One quotient bit per cycle; the dividend register fills with quotient bits.
    always_comb
    begin
        part = {rem_reg, num_reg[NUM_W-1]};
        part_diff = part - {1'b0, den_reg};
        ge = (part >= {1'b0, den_reg});
        rem_next = ge ? part_diff[DEN_W-1:0] : part[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = (cnt_reg == '0);
    assign quot = num_reg;
    assign rem = rem_reg;
endmodule

/* hdl/lfpd_motor.sv */
module lfpd_motor (
    input  logic signed [15:0] drive,
    input  logic [9:0]         base_duty,
    input  logic [9:0]         max_duty,
    output logic [9:0]         left_duty,
    output logic               left_forward,
    output logic [9:0]         right_duty,
    output logic               right_forward
);
    logic signed [20:0] d15;
    logic signed [20:0] d15_adj;
    logic signed [16:0] d15_q;
    logic signed [15:0] d1_adj;
    logic signed [11:0] d1_q;
    logic signed [18:0] base_s;
    logic signed [18:0] left_s;
    logic signed [18:0] right_s;
    logic               neg;

    function automatic logic [9:0] clamp_mag(input logic signed [18:0] duty,
                                             input logic [9:0] limit);
        logic [18:0] mag;
        begin
            mag = duty[18] ? 19'(-duty) : 19'(duty);
            if (mag > {9'd0, limit})
            begin
                clamp_mag = limit;
            end
            else
            begin
                clamp_mag = mag[9:0];
            end
        end
    endfunction

    // Both splits divide by 16 with truncation toward zero.
    always_comb
    begin
        neg = drive[15];
        d15 = (21'(drive) <<< 4) - 21'(drive);
        d15_adj = neg ? d15 + 21'sd15 : d15;
        d15_q = 17'(d15_adj >>> 4);
        d1_adj = neg ? drive + 16'sd15 : drive;
        d1_q = 12'(d1_adj >>> 4);
        base_s = $signed({9'd0, base_duty});
        if (neg)
        begin
            left_s = base_s + 19'(d15_q);
            right_s = base_s - 19'(d1_q);
        end
        else
        begin
            left_s = base_s + 19'(d1_q);
            right_s = base_s - 19'(d15_q);
        end
    end

    assign left_forward = !left_s[18];
    assign right_forward = !right_s[18];
    assign left_duty = clamp_mag(left_s, max_duty);
    assign right_duty = clamp_mag(right_s, max_duty);
endmodule
